// ===== design/dcpd_pkg.sv =====
// shared types and constants for the dark channel pixel dehaze block
package dcpd_pkg;

    // register indexes of the configuration port
    typedef enum logic [1:0] {
        CFG_AIRLIGHT = 2'd0,
        CFG_WEIGHT   = 2'd1,
        CFG_INVERT   = 2'd2
    } t_cfg_idx;

    localparam int CfgIdxW  = 2;
    localparam int CfgDataW = 8;

    localparam logic [7:0] AirlightRst = 8'd255;
    localparam logic [7:0] WeightRst   = 8'd218;
    localparam logic       InvertRst   = 1'b1;

    // half-unit transmission floor (0.1 of 255, doubled)
    localparam logic [8:0] ThFloor = 9'd51;

    // pipeline layout
    localparam int TDivFirst = 2;   // first transmission divide step
    localparam int ThStage   = 10;  // half-unit transmission and products
    localparam int MagStage  = 11;  // numerator and magnitude
    localparam int SatStage  = 12;  // overflow check
    localparam int CDivFirst = 13;  // first channel divide step
    localparam int NumStages = 22;  // last stage formats the output

    typedef struct packed {
        logic [7:0] in_red;
        logic [7:0] in_green;
        logic [7:0] in_blue;
        logic [7:0] dark_value;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic [7:0] transmission;
        logic [7:0] raw_dark;
    } t_out_beat;

    // everything one pixel carries down the pipeline
    typedef struct packed {
        logic [2:0][7:0]  pix;
        logic [7:0]       air;
        logic [7:0]       mn;
        logic [23:0]      rem;
        logic [7:0]       tq;
        logic [8:0]       th;
        logic [16:0]      ath;
        logic [2:0][18:0] sv;
        logic [2:0][17:0] mag;
        logic [2:0]       sat;
        logic [2:0][7:0]  cq;
    } t_pipe;

endpackage

// ===== design/dark_channel_pixel_dehaze_top.sv =====
// dark channel prior pixel dehaze: pipelined transmission and recovery
//
//  channel   signals                                   beat
//  input     i_in_valid / o_in_ready / i_in_data       one pixel and its filtered dark value
//  output    o_out_valid / i_out_ready / o_out_data    recovered pixel, transmission, raw dark
//  config    i_cfg_we / i_cfg_idx / i_cfg_data         one register write
//
// 22 register stages: one pixel enters per clock while the output is not stalled.
// two restoring dividers take one quotient bit per stage
// (8 stages for the transmission, 8 for the channel recovery).
// synchronous active-low reset clears stage valid bits and the configuration registers.
// each stage holds only when it is full and the stage after it holds.
module dark_channel_pixel_dehaze_top (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  dcpd_pkg::t_in_beat        i_in_data,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output dcpd_pkg::t_out_beat       o_out_data,
    input  logic                      i_cfg_we,
    input  logic [dcpd_pkg::CfgIdxW-1:0]  i_cfg_idx,
    input  logic [dcpd_pkg::CfgDataW-1:0] i_cfg_data
);
    import dcpd_pkg::*;

    logic [7:0] r_air;
    logic [7:0] r_weight;
    logic       r_invert;

    t_pipe          r_pl  [NumStages];
    t_pipe          n_pl  [NumStages];
    logic [NumStages-1:0] r_vld;
    logic [NumStages:0]   w_adv;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_air    <= AirlightRst;
            r_weight <= WeightRst;
            r_invert <= InvertRst;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_AIRLIGHT: r_air    <= i_cfg_data[7:0];
                CFG_WEIGHT:   r_weight <= i_cfg_data[7:0];
                CFG_INVERT:   r_invert <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // stall chain: a stage moves when empty or when the next one moves
    assign w_adv[NumStages] = i_out_ready;
    genvar g;
    generate
        for (g = 0; g < NumStages; g++) begin : g_adv
            assign w_adv[g] = !r_vld[g] || w_adv[g+1];
        end
    endgenerate

    assign o_in_ready = w_adv[0];

    // stage logic
    generate
        for (g = 0; g < NumStages; g++) begin : g_stage
            if (g == 0) begin : g_in
                // input complement, airlight floor, raw dark, weight product
                always_comb begin
                    logic [7:0] r, gr, b;
                    r  = r_invert ? ~i_in_data.in_red   : i_in_data.in_red;
                    gr = r_invert ? ~i_in_data.in_green : i_in_data.in_green;
                    b  = r_invert ? ~i_in_data.in_blue  : i_in_data.in_blue;
                    n_pl[g]        = '0;
                    n_pl[g].pix[0] = r;
                    n_pl[g].pix[1] = gr;
                    n_pl[g].pix[2] = b;
                    n_pl[g].air    = (r_air == 8'd0) ? 8'd1 : r_air;
                    n_pl[g].mn     = (r < gr) ? ((r < b) ? r : b) : ((gr < b) ? gr : b);
                    n_pl[g].rem    = {8'h0, 16'(r_weight) * 16'(i_in_data.dark_value)};
                end
            end else if (g == 1) begin : g_num
                // numerator 255*(256A - w*d), zero when not positive
                always_comb begin
                    logic [15:0] diff;
                    n_pl[g] = r_pl[g-1];
                    diff    = {r_pl[g-1].air, 8'h0} - r_pl[g-1].rem[15:0];
                    if (r_pl[g-1].rem[15:0] >= {r_pl[g-1].air, 8'h0})
                        n_pl[g].rem = '0;
                    else
                        n_pl[g].rem = {diff, 8'h0} - {8'h0, diff};
                    n_pl[g].tq = '0;
                end
            end else if (g < ThStage) begin : g_tdiv
                // one transmission quotient bit
                localparam int Bit = 7 - (g - TDivFirst);
                always_comb begin
                    logic [23:0] dv;
                    n_pl[g] = r_pl[g-1];
                    dv      = {8'h0, r_pl[g-1].air, 8'h0} << Bit;
                    if (r_pl[g-1].rem >= dv) begin
                        n_pl[g].rem     = r_pl[g-1].rem - dv;
                        n_pl[g].tq[Bit] = 1'b1;
                    end
                end
            end else if (g == ThStage) begin : g_th
                // half-unit transmission, A*th and (I-A)*510
                always_comb begin
                    logic [8:0] th;
                    logic signed [18:0] d;
                    n_pl[g] = r_pl[g-1];
                    th = ({r_pl[g-1].tq, 1'b0} < ThFloor) ? ThFloor : {r_pl[g-1].tq, 1'b0};
                    n_pl[g].th  = th;
                    n_pl[g].ath = r_pl[g-1].air * th;
                    for (int c = 0; c < 3; c++) begin
                        d = 19'($signed({1'b0, r_pl[g-1].pix[c]}) -
                                $signed({1'b0, r_pl[g-1].air}));
                        n_pl[g].sv[c] = 19'((d <<< 9) - (d <<< 1));
                    end
                end
            end else if (g == MagStage) begin : g_mag
                // numerator and its magnitude
                always_comb begin
                    logic signed [18:0] nn;
                    n_pl[g] = r_pl[g-1];
                    for (int c = 0; c < 3; c++) begin
                        nn = $signed(r_pl[g-1].sv[c]) + $signed({2'b00, r_pl[g-1].ath});
                        n_pl[g].mag[c] = nn[18] ? 18'(-nn) : nn[17:0];
                    end
                end
            end else if (g == SatStage) begin : g_sat
                // quotient of 256 or more saturates
                always_comb begin
                    n_pl[g] = r_pl[g-1];
                    for (int c = 0; c < 3; c++) begin
                        n_pl[g].sat[c] = r_pl[g-1].mag[c] >= {1'b0, r_pl[g-1].th, 8'h0};
                        n_pl[g].cq[c]  = '0;
                    end
                end
            end else if (g < NumStages - 1) begin : g_cdiv
                // one channel quotient bit per lane
                localparam int Bit = 7 - (g - CDivFirst);
                always_comb begin
                    logic [17:0] dv;
                    n_pl[g] = r_pl[g-1];
                    dv      = {9'h0, r_pl[g-1].th} << Bit;
                    for (int c = 0; c < 3; c++) begin
                        if (r_pl[g-1].mag[c] >= dv) begin
                            n_pl[g].mag[c]     = r_pl[g-1].mag[c] - dv;
                            n_pl[g].cq[c][Bit] = 1'b1;
                        end
                    end
                end
            end else begin : g_out
                // saturate and output complement
                always_comb begin
                    logic [7:0] v;
                    n_pl[g] = r_pl[g-1];
                    for (int c = 0; c < 3; c++) begin
                        v = r_pl[g-1].sat[c] ? 8'hFF : r_pl[g-1].cq[c];
                        n_pl[g].cq[c] = r_invert ? ~v : v;
                    end
                end
            end

            // stage registers
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[g] <= 1'b0;
                end else if (w_adv[g]) begin
                    r_vld[g] <= (g == 0) ? i_in_valid : r_vld[(g == 0) ? 0 : g-1];
                end
            end

            always_ff @(posedge i_clk) begin
                if (w_adv[g]) begin
                    r_pl[g] <= n_pl[g];
                end
            end
        end
    endgenerate

    // output beat
    assign o_out_valid             = r_vld[NumStages-1];
    assign o_out_data.out_red      = r_pl[NumStages-1].cq[0];
    assign o_out_data.out_green    = r_pl[NumStages-1].cq[1];
    assign o_out_data.out_blue     = r_pl[NumStages-1].cq[2];
    assign o_out_data.transmission = r_pl[NumStages-1].tq;
    assign o_out_data.raw_dark     = r_pl[NumStages-1].mn;

endmodule

// ===== test/dark_channel_pixel_dehaze_top_tb.sv =====
// testbench for the dark channel pixel dehaze block: random pixels checked against a predictor
`timescale 1ns / 1ps

module dark_channel_pixel_dehaze_top_tb;
    import dcpd_pkg::*;

    localparam int Latency = NumStages;
    localparam int CycleLimit = 400000;

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_ready;
    t_in_beat i_in_data;
    logic o_out_valid;
    logic i_out_ready;
    t_out_beat o_out_data;
    logic i_cfg_we;
    logic [CfgIdxW-1:0] i_cfg_idx;
    logic [CfgDataW-1:0] i_cfg_data;

    dark_channel_pixel_dehaze_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_data(o_out_data),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    // predictor copy of the registers
    logic [7:0] air_reg;
    logic [7:0] weight_reg;
    logic invert_reg;

    t_in_beat pixel_q[$];
    t_out_beat dehazed_q[$];
    int send_idle_pct;
    int recv_stall_pct;
    int hold_off_cycles;
    int mismatches;
    int cycles;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // recover one channel from its (possibly complemented) value
    function automatic logic [7:0] recover(input int p, input int a, input int th);
        int n;
        int v;
        n = (p - a) * 510 + a * th;
        if (n < 0) n = -n;
        v = n / th;
        return (v > 255) ? 8'd255 : v[7:0];
    endfunction

    function automatic t_out_beat dehaze(input t_in_beat b);
        t_out_beat r;
        int a, num, t, th, mn;
        int pix[3];
        a = (air_reg == 0) ? 1 : air_reg;
        pix[0] = invert_reg ? 255 - b.in_red : b.in_red;
        pix[1] = invert_reg ? 255 - b.in_green : b.in_green;
        pix[2] = invert_reg ? 255 - b.in_blue : b.in_blue;
        mn = pix[0];
        if (pix[1] < mn) mn = pix[1];
        if (pix[2] < mn) mn = pix[2];
        num = 255 * (256 * a - int'(weight_reg) * int'(b.dark_value));
        t = (num <= 0) ? 0 : num / (256 * a);
        th = (2 * t < 51) ? 51 : 2 * t;
        r.out_red = recover(pix[0], a, th);
        r.out_green = recover(pix[1], a, th);
        r.out_blue = recover(pix[2], a, th);
        if (invert_reg) begin
            r.out_red = 8'd255 - r.out_red;
            r.out_green = 8'd255 - r.out_green;
            r.out_blue = 8'd255 - r.out_blue;
        end
        r.transmission = t[7:0];
        r.raw_dark = mn[7:0];
        return r;
    endfunction

    // input driver: offers the next pending pixel, records prediction on accept
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                dehazed_q.push_back(dehaze(i_in_data));
            end
            if (!i_in_valid || o_in_ready) begin
                if (pixel_q.size() > 0 && $urandom_range(99, 0) >= send_idle_pct) begin
                    i_in_data <= pixel_q.pop_front();
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // output monitor with random stalls and an optional long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (dehazed_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected beat %h", o_out_data);
                end else begin
                    t_out_beat e;
                    e = dehazed_q.pop_front();
                    if (e !== o_out_data) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: expected r%0d g%0d b%0d t%0d d%0d, ",
                                      "got r%0d g%0d b%0d t%0d d%0d"},
                                e.out_red, e.out_green, e.out_blue, e.transmission, e.raw_dark,
                                o_out_data.out_red, o_out_data.out_green, o_out_data.out_blue,
                                o_out_data.transmission, o_out_data.raw_dark);
                    end
                end
            end
            if (hold_off_cycles > 0) begin
                hold_off_cycles <= hold_off_cycles - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99, 0) >= recv_stall_pct);
            end
        end
    end

    // run-length watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic write_reg(input t_cfg_idx idx, input logic [7:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_AIRLIGHT: air_reg = val;
            CFG_WEIGHT:   weight_reg = val;
            default:      invert_reg = val[0];
        endcase
    endtask

    task automatic drain();
        while (pixel_q.size() > 0 || i_in_valid || dehazed_q.size() > 0) @(posedge i_clk);
        repeat (Latency + 4) @(posedge i_clk);
    endtask

    task automatic add_pixel(input int r, input int g, input int b, input int d);
        t_in_beat p;
        p.in_red = 8'(r);
        p.in_green = 8'(g);
        p.in_blue = 8'(b);
        p.dark_value = 8'(d);
        pixel_q.push_back(p);
    endtask

    task automatic add_random(input int n);
        repeat (n) add_pixel($urandom_range(255, 0), $urandom_range(255, 0),
                             $urandom_range(255, 0), $urandom_range(255, 0));
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_out_ready = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        cycles = 0;
        mismatches = 0;
        hold_off_cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        air_reg = AirlightRst;
        weight_reg = WeightRst;
        invert_reg = InvertRst;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, zero airlight, negative and floored transmission, overflow
        add_pixel(0, 0, 0, 0);
        add_pixel(255, 255, 255, 255);
        add_pixel(255, 0, 128, 0);
        add_pixel(0, 255, 1, 255);
        add_pixel(170, 85, 15, 240);
        drain();
        write_reg(CFG_INVERT, 8'd0);
        add_pixel(0, 0, 0, 255);
        add_pixel(255, 255, 255, 0);
        add_pixel(255, 10, 200, 200);
        add_pixel(85, 170, 240, 15);
        drain();
        write_reg(CFG_AIRLIGHT, 8'd0);
        write_reg(CFG_WEIGHT, 8'd255);
        add_pixel(0, 255, 128, 0);
        add_pixel(255, 255, 0, 1);
        add_pixel(7, 200, 255, 255);
        drain();
        write_reg(CFG_AIRLIGHT, 8'd20);
        write_reg(CFG_WEIGHT, 8'd0);
        add_pixel(255, 0, 100, 255);
        add_pixel(255, 255, 255, 0);
        drain();
        write_reg(CFG_WEIGHT, 8'd255);
        write_reg(CFG_INVERT, 8'd1);
        add_pixel(0, 0, 255, 255);
        add_pixel(255, 128, 3, 10);
        drain();

        // random phases, each with its own settings and idling
        for (int ph = 0; ph < 8; ph++) begin
            write_reg(CFG_AIRLIGHT,
                      (ph == 1) ? 8'd255 : (ph == 2) ? 8'd1 : 8'($urandom_range(255, 0)));
            write_reg(CFG_WEIGHT, (ph == 3) ? 8'd0 : 8'($urandom_range(255, 0)));
            write_reg(CFG_INVERT, {7'h0, ph[0]});
            case (ph % 4)
                0: begin send_idle_pct = 0; recv_stall_pct = 0; end
                1: begin send_idle_pct = 87; recv_stall_pct = 0; end
                2: begin send_idle_pct = 0; recv_stall_pct = 87; end
                default: begin send_idle_pct = 36; recv_stall_pct = 36; end
            endcase
            if (ph == 4) hold_off_cycles = 300;
            add_random(228);
            drain();
        end

        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
design/dcpd_pkg.sv
design/dark_channel_pixel_dehaze_top.sv
test/dark_channel_pixel_dehaze_top_tb.sv
